/* rtl/pics_pkg.sv */
// constants, types and state codes shared by the poisson sampler modules
package pics_pkg;

   localparam int KMAX     = 127;
   localparam int K_W      = $clog2(KMAX + 1);
   localparam int COUNT_W  = 7;
   localparam int PROB_W   = 32;
   localparam int LAMBDA_W = 21;
   localparam int TOL_W    = 16;
   localparam int FRAC_W   = 16;
   localparam int PROD_W   = PROB_W + LAMBDA_W;
   localparam int DIVD_W   = PROD_W - FRAC_W;
   localparam int DCNT_W   = $clog2(DIVD_W);
   localparam int SUM_W    = PROB_W + K_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;

   localparam logic [LAMBDA_W-1:0] RATE_RESET = '0;
   localparam logic [PROB_W-1:0]   EXP_RESET  = '1;
   localparam logic [TOL_W-1:0]    TOL_RESET  = TOL_W'(4295);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RATE_LAMBDA  = 2'd0,
      CSR_EXP_NEG_RATE = 2'd1,
      CSR_TOLERANCE    = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL,
      ST_DIV,
      ST_ACC,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic next_k;
      logic force_kmax;
      logic mul;
      logic div_step;
      logic accumulate;
      logic deliver;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic k_max;
      logic term_zero;
      logic div_last;
   } status_type;

endpackage

/* rtl/pics_ctrl.sv */
// control state machine sequencing the term multiply, divide and accumulate
module pics_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 out_free,
   input  pics_pkg::status_type status,
   output pics_pkg::cmd_type    cmd
);

   pics_pkg::state_type state_ff;
   pics_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pics_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         pics_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = pics_pkg::ST_CHECK;
            end
         end
         pics_pkg::ST_CHECK: begin
            priority if (status.hit || status.k_max) begin
               state_in = pics_pkg::ST_DONE;
            end else if (status.term_zero) begin
               // later terms stay zero, so the search ends at the limit
               cmd.force_kmax = 1'b1;
               state_in       = pics_pkg::ST_DONE;
            end else begin
               cmd.next_k = 1'b1;
               state_in   = pics_pkg::ST_MUL;
            end
         end
         pics_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = pics_pkg::ST_DIV;
         end
         pics_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = pics_pkg::ST_ACC;
            end
         end
         pics_pkg::ST_ACC: begin
            cmd.accumulate = 1'b1;
            state_in       = pics_pkg::ST_CHECK;
         end
         pics_pkg::ST_DONE: begin
            if (out_free) begin
               cmd.deliver = 1'b1;
               state_in    = pics_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pics_pkg::ST_IDLE;
         end
      endcase
   end

   a_div_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pics_pkg::ST_DIV && !status.div_last) |=> state_ff == pics_pkg::ST_DIV)
      else $error("divider left before its last step");

   a_done_reason: assert property (@(posedge clock) disable iff (reset)
      state_ff == pics_pkg::ST_DONE |-> (status.hit || status.k_max))
      else $error("search finished without reaching target or limit");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == pics_pkg::ST_IDLE)
      else $error("word loaded while busy");

endmodule

/* rtl/pics_dp.sv */
// datapath: term register, multiplier, restoring divider and running sum
module pics_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  pics_pkg::cmd_type               cmd,
   output pics_pkg::status_type            status,
   input  logic [pics_pkg::PROB_W-1:0]     uniform_value,
   input  logic [pics_pkg::LAMBDA_W-1:0]   rate_lambda,
   input  logic [pics_pkg::PROB_W-1:0]     exp_neg_rate,
   input  logic [pics_pkg::TOL_W-1:0]      tolerance,
   output logic [pics_pkg::COUNT_W-1:0]    event_count,
   output logic                            saturated
);

   logic [pics_pkg::PROB_W-1:0] target_ff, target_in;
   logic [pics_pkg::PROB_W-1:0] term_ff, term_in;
   logic [pics_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic [pics_pkg::K_W-1:0]    k_ff, k_in;
   logic [pics_pkg::DIVD_W-1:0] quo_ff, quo_in;
   logic [pics_pkg::K_W-1:0]    rem_ff, rem_in;
   logic [pics_pkg::DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [pics_pkg::PROD_W-1:0] product;
   logic [pics_pkg::K_W:0]      trial;
   logic                        trial_ge;
   logic [pics_pkg::PROB_W-1:0] next_term;

   assign product  = term_ff * rate_lambda;
   assign trial    = {rem_ff, quo_ff[pics_pkg::DIVD_W-1]};
   assign trial_ge = trial >= {1'b0, k_ff};
   assign next_term = (quo_ff > pics_pkg::DIVD_W'({pics_pkg::PROB_W{1'b1}}))
                      ? {pics_pkg::PROB_W{1'b1}} : quo_ff[pics_pkg::PROB_W-1:0];

   always_comb begin
      target_in = target_ff;
      term_in   = term_ff;
      sum_in    = sum_ff;
      k_in      = k_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dcnt_in   = dcnt_ff;
      if (cmd.load) begin
         target_in = (uniform_value > pics_pkg::PROB_W'(tolerance))
                     ? uniform_value - pics_pkg::PROB_W'(tolerance) : '0;
         term_in   = exp_neg_rate;
         sum_in    = pics_pkg::SUM_W'(exp_neg_rate);
         k_in      = '0;
      end
      if (cmd.next_k) begin
         k_in = k_ff + pics_pkg::K_W'(1);
      end
      if (cmd.force_kmax) begin
         k_in = pics_pkg::K_W'(pics_pkg::KMAX);
      end
      if (cmd.mul) begin
         quo_in  = product[pics_pkg::PROD_W-1:pics_pkg::FRAC_W];
         rem_in  = '0;
         dcnt_in = pics_pkg::DCNT_W'(pics_pkg::DIVD_W - 1);
      end
      if (cmd.div_step) begin
         rem_in  = trial_ge ? pics_pkg::K_W'(trial - {1'b0, k_ff}) : trial[pics_pkg::K_W-1:0];
         quo_in  = {quo_ff[pics_pkg::DIVD_W-2:0], trial_ge};
         dcnt_in = dcnt_ff - pics_pkg::DCNT_W'(1);
      end
      if (cmd.accumulate) begin
         term_in = next_term;
         sum_in  = sum_ff + pics_pkg::SUM_W'(next_term);
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      term_ff   <= term_in;
      sum_ff    <= sum_in;
      k_ff      <= k_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      dcnt_ff   <= dcnt_in;
   end

   always_comb begin
      status.hit       = sum_ff >= pics_pkg::SUM_W'(target_ff);
      status.k_max     = k_ff == pics_pkg::K_W'(pics_pkg::KMAX);
      status.term_zero = term_ff == '0;
      status.div_last  = dcnt_ff == '0;
   end

   assign event_count = pics_pkg::COUNT_W'(k_ff);
   assign saturated   = ~status.hit;

   a_k_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.next_k || cmd.force_kmax) |=> k_ff <= pics_pkg::K_W'(pics_pkg::KMAX))
      else $error("count beyond limit");

   a_sum_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.accumulate |=> sum_ff >= $past(sum_ff))
      else $error("running sum wrapped");

endmodule

/* rtl/poisson_inverse_cdf_sampler_top.sv */
// top level of the poisson inverse transform sampler with registers and output stage
//
// channel | direction | fields (low bit first)
// req     | in        | tdata: uniform_value[31:0]
// rsp     | out       | tdata: event_count[6:0], zero pad; tuser: saturated
// csr     | in        | index 0 rate_lambda, 1 exp_neg_rate, 2 tolerance
//
// after a word is accepted, terms are computed until the search ends and the result
// is registered; a term is one test, one multiply, 37 restoring divide steps and one
// accumulate. a zero term ends the search at once at the limit.
// reset is synchronous; the configuration registers return to their reset values.
// a finished search waits while the output register holds an unaccepted word.
// a new word is taken while the previous result waits in the output register.
module poisson_inverse_cdf_sampler_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [pics_pkg::REQ_DATA_W-1:0]    req_tdata,   // uniform_value
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [pics_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // event_count, pad
   output logic                               rsp_tuser,   // saturated
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pics_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pics_pkg::CSR_DATA_W-1:0]    csr_data
);

   logic [pics_pkg::LAMBDA_W-1:0] rate_ff;
   logic [pics_pkg::PROB_W-1:0]   exp_ff;
   logic [pics_pkg::TOL_W-1:0]    tol_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pics_pkg::COUNT_W-1:0]  count_ff;
   logic                          sat_ff;
   logic [pics_pkg::COUNT_W-1:0]  event_count;
   logic                          saturated;
   logic                          out_free;
   pics_pkg::cmd_type             cmd;
   pics_pkg::status_type          status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= pics_pkg::RATE_RESET;
         exp_ff  <= pics_pkg::EXP_RESET;
         tol_ff  <= pics_pkg::TOL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            pics_pkg::CSR_RATE_LAMBDA:  rate_ff <= csr_data[pics_pkg::LAMBDA_W-1:0];
            pics_pkg::CSR_EXP_NEG_RATE: exp_ff  <= csr_data[pics_pkg::PROB_W-1:0];
            pics_pkg::CSR_TOLERANCE:    tol_ff  <= csr_data[pics_pkg::TOL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.deliver) begin
         count_ff <= event_count;
         sat_ff   <= saturated;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = pics_pkg::RSP_DATA_W'(count_ff);
   assign rsp_tuser  = sat_ff;

   pics_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .out_free   (out_free),
      .status     (status),
      .cmd        (cmd)
   );

   pics_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .uniform_value (req_tdata[pics_pkg::PROB_W-1:0]),
      .rate_lambda   (rate_ff),
      .exp_neg_rate  (exp_ff),
      .tolerance     (tol_ff),
      .event_count   (event_count),
      .saturated     (saturated)
   );

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.deliver |-> out_free)
      else $error("result register overwritten");

endmodule
